### src/rsm_pkg.sv
// Shared types and constants for the random step modulator.
package rsm_pkg;

  localparam int FX_W        = 17;
  localparam int PHASE_W     = 32;
  localparam int LFSR_W      = 32;
  localparam int RAND_W      = 16;
  localparam int SEQ_IDX_W   = 4;
  localparam int SEQ_LEN_W   = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int SEQ_DEPTH_DEF = 16;

  localparam logic [FX_W-1:0]   ONE_FX    = FX_W'(65536);
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'hD000_0001;

  // floor(x / 10) as (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below 2^18
  localparam int              DIV10_SHIFT = 20;
  localparam logic [FX_W-1:0] DIV10_MUL   = FX_W'(104858);

  typedef enum logic {
    OP_TICK      = 1'b0,
    OP_SEQ_WRITE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    MODE_NOISE    = 3'd0,
    MODE_CRAWL    = 3'd1,
    MODE_INTERVAL = 3'd2,
    MODE_CHAOS    = 3'd3,
    MODE_SEQUENCE = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 3'd0,
    CFG_PHASE_INC  = 3'd1,
    CFG_AMPLITUDE  = 3'd2,
    CFG_KEEP       = 3'd3,
    CFG_SEQ_LENGTH = 3'd4,
    CFG_RNG_SEED   = 3'd5
  } cfg_idx_t;

endpackage

### src/random_step_modulator.sv
// Top level of the stepped random modulation source.
//
// Usage:
//   Input channel (in_valid / in_stall): each word is either a sample tick
//   (in_op = tick) or a sequence table write (in_op = table write, with
//   in_seq_index and in_seq_value). A tick produces exactly one output word
//   carrying the held modulation value; a table write produces none.
//   Output channel (out_valid / out_stall): one word per tick, in order.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   cfg_ready is always high; write only while no tick is in flight.
//   Throughput: one word per cycle while the receiver does not stall the
//   output; the whole update is one pass of logic from the state registers
//   into the output register, with the LFSR stepped twice, one 16x17
//   multiply and one 17x17 constant multiply in that pass.
//   Stall: in_stall rises only while a finished word sits in the output
//   register and the receiver stalls it; the output word then holds.
//   Reset (synchronous, rst_n low): registers return to mode noise, zero
//   increment, amplitude and keep chance, length 1, seed 1; phase, held
//   value, direction/index and the sequence table clear; LFSR loads 1.
//   Values are unsigned fixed point with 65536 meaning 1.0.
module random_step_modulator #(
  parameter int SEQ_DEPTH = rsm_pkg::SEQ_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [rsm_pkg::SEQ_IDX_W-1:0]    in_seq_index,
  input  logic [rsm_pkg::FX_W-1:0]         in_seq_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rsm_pkg::FX_W-1:0]         out_mod_value,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rsm_pkg::*;

  // Index width for the table; length compare width holds SEQ_DEPTH and the
  // 5-bit length register.
  localparam int IDX_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int LW    = ($clog2(SEQ_DEPTH + 1) > SEQ_LEN_W) ?
                         $clog2(SEQ_DEPTH + 1) : SEQ_LEN_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(SEQ_DEPTH);

  // configuration registers
  logic [2:0]           mode_r;
  logic [PHASE_W-1:0]   phase_inc_r;
  logic [FX_W-1:0]      amp_r;
  logic [FX_W-1:0]      keep_r;
  logic [SEQ_LEN_W-1:0] seq_len_r;

  // running state
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [FX_W-1:0]      held_r, held_nxt;
  logic [IDX_W-1:0]     dir_r, dir_nxt;
  logic [LFSR_W-1:0]    lfsr_r, lfsr_nxt;
  logic [FX_W-1:0]      seq_table_r [SEQ_DEPTH];

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [FX_W-1:0]      out_value_r, out_value_nxt;

  logic                 in_fire, out_fire, cfg_fire, tick_fire, tbl_fire;

  // intermediate terms of the update
  logic [LFSR_W-1:0]    lfsr_1, lfsr_2;
  logic [RAND_W-1:0]    rnd_1, rnd_2, rnd_mul;
  logic [FX_W-1:0]      amp_sat;
  logic [RAND_W+FX_W-1:0] prod;
  logic [FX_W-1:0]      scaled;
  logic [FX_W:0]        noise_sum;
  logic [2*FX_W-1:0]    step_prod;
  logic [FX_W-1:0]      step;
  logic [FX_W:0]        up_sum;
  logic                 change;
  logic [LW-1:0]        eff_len, idx_inc;
  logic [IDX_W-1:0]     idx_next;
  logic [PHASE_W:0]     phase_sum;
  logic [FX_W-1:0]      tbl_value;
  logic [IDX_W-1:0]     tbl_addr;
  logic                 tbl_in_range;
  logic [LFSR_W-1:0]    seed_load;

  // handshakes: take a new word unless the output register is stuck
  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign out_fire  = out_valid_r & ~out_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign tick_fire = in_fire & (in_op == OP_TICK);
  assign tbl_fire  = in_fire & (in_op == OP_SEQ_WRITE);

  assign out_valid     = out_valid_r;
  assign out_mod_value = out_value_r;

  // Two Galois LFSR draws; chaos mode uses the second one for the value.
  assign lfsr_1  = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);
  assign lfsr_2  = (lfsr_1 >> 1) ^ (lfsr_1[0] ? LFSR_TAPS : '0);
  assign rnd_1   = lfsr_1[LFSR_W-1 -: RAND_W];
  assign rnd_2   = lfsr_2[LFSR_W-1 -: RAND_W];
  assign rnd_mul = (mode_r == MODE_CHAOS) ? rnd_2 : rnd_1;

  assign amp_sat   = (amp_r > ONE_FX) ? ONE_FX : amp_r;
  assign prod      = (RAND_W + FX_W)'(rnd_mul) * (RAND_W + FX_W)'(amp_sat);
  assign scaled    = prod[RAND_W +: FX_W];
  assign noise_sum = {1'b0, scaled} + {1'b0, keep_r};
  assign change    = {1'b0, rnd_1} > keep_r;

  // crawl step size: amplitude / 10 by reciprocal multiply
  assign step_prod = (2*FX_W)'(amp_sat) * (2*FX_W)'(DIV10_MUL);
  assign step      = FX_W'(step_prod[2*FX_W-1:DIV10_SHIFT]);
  assign up_sum    = {1'b0, held_r} + {1'b0, step};

  // sequence index: advance, wrap at the clamped length
  always_comb begin
    eff_len = LW'(seq_len_r);
    if (eff_len == '0) begin
      eff_len = LW'(1);
    end else if (eff_len > DEPTH_L) begin
      eff_len = DEPTH_L;
    end
  end
  assign idx_inc  = LW'(dir_r) + LW'(1);
  assign idx_next = (idx_inc >= eff_len) ? '0 : IDX_W'(idx_inc);

  assign phase_sum = {1'b0, phase_r} + {1'b0, phase_inc_r};

  // new held value, direction/index and LFSR for a tick
  always_comb begin
    held_nxt = held_r;
    dir_nxt  = dir_r;
    lfsr_nxt = lfsr_r;
    if (phase_r == '0) begin
      case (mode_r)
        MODE_NOISE: begin
          lfsr_nxt = lfsr_1;
          held_nxt = (noise_sum > {1'b0, ONE_FX}) ? ONE_FX : noise_sum[FX_W-1:0];
        end
        MODE_CRAWL: begin
          lfsr_nxt = lfsr_1;
          if (dir_r == '0) begin
            held_nxt = (up_sum > {1'b0, ONE_FX}) ? ONE_FX : up_sum[FX_W-1:0];
          end else begin
            held_nxt = (held_r > step) ? held_r - step : '0;
          end
          if (change) begin
            dir_nxt = (dir_r == '0) ? IDX_W'(1) : '0;
          end
        end
        MODE_INTERVAL: begin
          lfsr_nxt = lfsr_1;
          if (change) begin
            held_nxt = (held_r == amp_sat) ? '0 : amp_sat;
          end
        end
        MODE_CHAOS: begin
          lfsr_nxt = lfsr_1;
          if (change) begin
            lfsr_nxt = lfsr_2;
            held_nxt = scaled;
          end
        end
        MODE_SEQUENCE: begin
          dir_nxt  = idx_next;
          held_nxt = seq_table_r[idx_next];
        end
        default: begin
          // unused mode codes: hold everything
        end
      endcase
    end
    // phase reaching 1.0 snaps to zero instead of wrapping
    phase_nxt = phase_sum[PHASE_W] ? '0 : phase_sum[PHASE_W-1:0];
  end

  // output register: load on a tick, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (tick_fire) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = held_nxt;
    end
  end

  // table write: clamp value to 1.0, ignore indexes past the table
  assign tbl_value    = (in_seq_value > ONE_FX) ? ONE_FX : in_seq_value;
  assign tbl_in_range = LW'(in_seq_index) < DEPTH_L;
  assign tbl_addr     = IDX_W'(in_seq_index);
  assign seed_load    = (cfg_data == '0) ? LFSR_W'(1) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NOISE;
      phase_inc_r <= '0;
      amp_r       <= '0;
      keep_r      <= '0;
      seq_len_r   <= SEQ_LEN_W'(1);
      phase_r     <= '0;
      held_r      <= '0;
      dir_r       <= '0;
      lfsr_r      <= LFSR_W'(1);
      out_valid_r <= 1'b0;
      out_value_r <= '0;
      for (int i = 0; i < SEQ_DEPTH; i++) begin
        seq_table_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      out_value_r <= out_value_nxt;
      if (tick_fire) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        dir_r   <= dir_nxt;
        lfsr_r  <= lfsr_nxt;
      end
      if (tbl_fire && tbl_in_range) begin
        seq_table_r[tbl_addr] <= tbl_value;
      end
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_MODE: begin
            mode_r <= cfg_data[2:0];
            dir_r  <= '0;
          end
          CFG_PHASE_INC:  phase_inc_r <= cfg_data;
          CFG_AMPLITUDE:  amp_r       <= cfg_data[FX_W-1:0];
          CFG_KEEP:       keep_r      <= cfg_data[FX_W-1:0];
          CFG_SEQ_LENGTH: seq_len_r   <= cfg_data[SEQ_LEN_W-1:0];
          CFG_RNG_SEED:   lfsr_r      <= seed_load;
          default: begin
            // unmapped index: drop the write
          end
        endcase
      end
    end
  end

endmodule

### src/rsm_checker.sv
// Port-level checks for the random step modulator, bound to its top level.
module rsm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_op,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [rsm_pkg::FX_W-1:0]         out_mod_value
);
  import rsm_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mod_value))
    else $error("stalled output word changed or dropped");

  // the input side stalls only behind a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output word");

  // every accepted tick shows a word on the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_TICK) |=> out_valid)
    else $error("tick accepted without a result word");

  // a table write alone never invents an output word
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_op == OP_SEQ_WRITE) && !(out_valid && !out_stall)
    |=> out_valid == $past(out_valid))
    else $error("table write changed output occupancy");

  // modulation values never exceed 1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mod_value <= ONE_FX)
    else $error("modulation value above 1.0");

endmodule

bind random_step_modulator rsm_checker u_rsm_checker (.*);

### dv/random_step_modulator_checker.sv
`timescale 1ns / 100ps
// Checker for the random step modulator: predicts each held value and compares output words.
module random_step_modulator_checker
  import rsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_op,
  input  logic [SEQ_IDX_W-1:0]  in_seq_index,
  input  logic [FX_W-1:0]       in_seq_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [FX_W-1:0]       out_mod_value,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    mod_values_pending
);

  localparam int TABLE_DEPTH = SEQ_DEPTH_DEF;

  // register copies
  logic [2:0]         mode_q;
  logic [PHASE_W-1:0] phase_inc_q;
  logic [FX_W-1:0]    amplitude_q;
  logic [FX_W-1:0]    keep_q;
  logic [SEQ_LEN_W-1:0] seq_len_q;

  // block state
  logic [PHASE_W-1:0] phase_q;
  logic [FX_W-1:0]    held_q;
  int                 dir_q;
  logic [LFSR_W-1:0]  lfsr_q;
  logic [FX_W-1:0]    seq_table [TABLE_DEPTH];

  logic [FX_W-1:0]    mod_values_due [$];
  logic [FX_W-1:0]    due_value;
  logic [PHASE_W:0]   phase_sum;
  int                 error_count;

  function automatic logic [FX_W-1:0] clamp_one(logic [63:0] v);
    return (v > 64'(ONE_FX)) ? ONE_FX : v[FX_W-1:0];
  endfunction

  // advance the Galois LFSR once, return its top half as the random fraction
  function automatic logic [RAND_W-1:0] next_fraction();
    lfsr_q = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
    return lfsr_q[LFSR_W-1 -: RAND_W];
  endfunction

  task automatic make_held_value();
    logic [FX_W-1:0]   amp;
    logic [FX_W-1:0]   step;
    logic [RAND_W-1:0] r;
    int                len;
    amp = clamp_one(64'(amplitude_q));
    case (mode_q)
      MODE_NOISE: begin
        r = next_fraction();
        held_q = clamp_one(((64'(r) * 64'(amp)) >> 16) + 64'(keep_q));
      end
      MODE_CRAWL: begin
        step = amp / 17'd10;
        if (dir_q == 0) held_q = clamp_one(64'(held_q) + 64'(step));
        else held_q = (held_q > step) ? held_q - step : '0;
        r = next_fraction();
        if (FX_W'(r) > keep_q) dir_q = (dir_q == 0) ? 1 : 0;
      end
      MODE_INTERVAL: begin
        r = next_fraction();
        if (FX_W'(r) > keep_q) held_q = (held_q == amp) ? '0 : amp;
      end
      MODE_CHAOS: begin
        r = next_fraction();
        if (FX_W'(r) > keep_q) begin
          r = next_fraction();
          held_q = FX_W'((64'(r) * 64'(amp)) >> 16);
        end
      end
      MODE_SEQUENCE: begin
        len = int'(seq_len_q);
        if (len == 0) len = 1;
        if (len > TABLE_DEPTH) len = TABLE_DEPTH;
        dir_q = dir_q + 1;
        if (dir_q >= len) dir_q = 0;
        held_q = seq_table[dir_q];
      end
      default: ;  // unused modes keep the held value and the LFSR
    endcase
  endtask

  task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MODE: begin
        mode_q = data[2:0];
        dir_q  = 0;
      end
      CFG_PHASE_INC:  phase_inc_q = data;
      CFG_AMPLITUDE:  amplitude_q = data[FX_W-1:0];
      CFG_KEEP:       keep_q      = data[FX_W-1:0];
      CFG_SEQ_LENGTH: seq_len_q   = data[SEQ_LEN_W-1:0];
      CFG_RNG_SEED:   lfsr_q      = (data == '0) ? LFSR_W'(1) : data;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q      = MODE_NOISE;
      phase_inc_q = '0;
      amplitude_q = '0;
      keep_q      = '0;
      seq_len_q   = SEQ_LEN_W'(1);
      phase_q     = '0;
      held_q      = '0;
      dir_q       = 0;
      lfsr_q      = LFSR_W'(1);
      foreach (seq_table[i]) seq_table[i] = '0;
      mod_values_due.delete();
      error_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mod_values_due.size() == 0) begin
          $error("mod_value: expected no word, actual %0d", out_mod_value);
          error_count++;
        end else begin
          due_value = mod_values_due.pop_front();
          if (out_mod_value !== due_value) begin
            $error("mod_value: expected %0d, actual %0d", due_value, out_mod_value);
            error_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        if (in_op == OP_SEQ_WRITE) begin
          seq_table[in_seq_index] = clamp_one(64'(in_seq_value));
        end else begin
          if (phase_q == '0) make_held_value();
          phase_sum = {1'b0, phase_q} + {1'b0, phase_inc_q};
          phase_q   = phase_sum[PHASE_W] ? '0 : phase_sum[PHASE_W-1:0];
          mod_values_due = {mod_values_due, held_q};
        end
      end
    end
    mismatches         <= error_count;
    mod_values_pending <= mod_values_due.size();
  end

endmodule

### dv/random_step_modulator_tb.sv
`timescale 1ns / 100ps
// Testbench top for the random step modulator: clock, reset, stimulus and verdict.
module random_step_modulator_tb;
  import rsm_pkg::*;

  localparam int RANDOM_WORDS = 2000;
  localparam int CYCLE_LIMIT  = 600000;
  // a mode code with no behavior behind it
  localparam logic [2:0] MODE_UNUSED = 3'd6;
  localparam int MODE_LAST_CODE = (1 << 3) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_op = OP_TICK;
  logic [SEQ_IDX_W-1:0]  in_seq_index = '0;
  logic [FX_W-1:0]       in_seq_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FX_W-1:0]       out_mod_value;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    mod_values_pending;

  // sender and receiver pacing, retuned per phase
  int stall_pct = 0;
  int stall_run = 0;
  int gap_max = 0;
  int burst_left = 0;
  int cycle_count = 0;

  random_step_modulator dut (.*);

  random_step_modulator_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result channel in runs: each run is all-stall or all-pass, and
  // its odds follow stall_pct, so a zero percentage gives a clean stream.
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      stall_run <= $urandom_range(0, 11);
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Hold one config write on the channel until taken. Leave cfg_valid high so
  // back-to-back writes never lower and raise it in one step; the next input
  // word drops it.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Send one word on the input channel. Words go out in bursts; between
  // bursts, drop valid for a random gap. Valid stays high across a burst.
  task automatic send_word(op_t op, logic [SEQ_IDX_W-1:0] idx, logic [FX_W-1:0] val);
    cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_op        <= op;
    in_seq_index <= idx;
    in_seq_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // A tick carries junk in the table fields; the block must ignore it.
  task automatic tick();
    send_word(OP_TICK, SEQ_IDX_W'($urandom()), FX_W'($urandom()));
  endtask

  // Hold off the sender until every predicted word has come out, then let
  // the pipeline settle before touching registers.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (mod_values_pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Pick a fresh setting for a phase. Junk in the unused upper bits of the
  // data word must be masked off by the block.
  task automatic random_config();
    logic [CFG_DATA_W-1:0] junk;
    logic [2:0]            mode_code;
    logic [CFG_DATA_W-1:0] amp;
    logic [CFG_DATA_W-1:0] keep;
    logic [CFG_DATA_W-1:0] inc;
    junk = $urandom();
    if ($urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 9) == 0)
        mode_code = 3'($urandom_range(int'(MODE_SEQUENCE) + 1, MODE_LAST_CODE));
      else
        mode_code = 3'($urandom_range(int'(MODE_NOISE), int'(MODE_SEQUENCE)));
      write_reg(CFG_MODE, {junk[CFG_DATA_W-1:3], mode_code});
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 4))
        0:       inc = '0;
        1:       inc = '1;
        2:       inc = 32'h8000_0000;
        3:       inc = $urandom();
        default: inc = $urandom_range(32'h0400_0000, 32'h4000_0000);
      endcase
      write_reg(CFG_PHASE_INC, inc);
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 4))
        0:       amp = '0;
        1:       amp = 32'(ONE_FX);
        2:       amp = $urandom_range(0, 65536);
        3:       amp = $urandom_range(65537, 131071);
        default: amp = $urandom();
      endcase
      write_reg(CFG_AMPLITUDE, amp);
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 5))
        0:       keep = '0;
        1:       keep = 32'(ONE_FX);
        2:       keep = $urandom_range(65537, 131071);
        3:       keep = $urandom();
        default: keep = $urandom_range(0, 65535);
      endcase
      write_reg(CFG_KEEP, keep);
    end
    if ($urandom_range(0, 2) != 0)
      write_reg(CFG_SEQ_LENGTH, {junk[CFG_DATA_W-1:5], 5'($urandom_range(0, 31))});
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_RNG_SEED, ($urandom_range(0, 7) == 0) ? '0 : $urandom());
    case ($urandom_range(0, 3))
      0:       stall_pct = 0;
      1:       stall_pct = 20;
      2:       stall_pct = 50;
      default: stall_pct = 85;
    endcase
    case ($urandom_range(0, 2))
      0:       gap_max = 0;
      1:       gap_max = 3;
      default: gap_max = 10;
    endcase
  endtask

  initial begin
    int sent;
    int batch;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: noise with zero amplitude and offset yields zeros.
    // Load table words at the value extremes, above one among them.
    tick();
    tick();
    send_word(OP_SEQ_WRITE, 4'd0, 17'h1FFFF);
    send_word(OP_SEQ_WRITE, 4'd15, ONE_FX);
    send_word(OP_SEQ_WRITE, 4'd7, 17'h10001);
    send_word(OP_SEQ_WRITE, 4'd3, 17'h0);
    drain();

    // Sequence: length past the table depth, then length zero.
    write_reg(CFG_MODE, 32'(MODE_SEQUENCE));
    write_reg(CFG_SEQ_LENGTH, 32'd17);
    tick();
    tick();
    tick();
    drain();
    write_reg(CFG_SEQ_LENGTH, 32'd0);
    tick();
    drain();

    // Noise with amplitude and offset above one, and a zero seed.
    write_reg(CFG_MODE, 32'(MODE_NOISE));
    write_reg(CFG_AMPLITUDE, 32'h1FFFF);
    write_reg(CFG_KEEP, 32'h1FFFF);
    write_reg(CFG_RNG_SEED, 32'd0);
    tick();
    tick();
    drain();

    // Crawl at full step; the largest increment holds every other tick.
    write_reg(CFG_MODE, 32'(MODE_CRAWL));
    write_reg(CFG_AMPLITUDE, 32'(ONE_FX));
    write_reg(CFG_KEEP, 32'd0);
    write_reg(CFG_PHASE_INC, 32'hFFFF_FFFF);
    tick();
    tick();
    tick();
    tick();
    drain();

    // Interval: a threshold of one never changes, zero always toggles.
    write_reg(CFG_MODE, 32'(MODE_INTERVAL));
    write_reg(CFG_KEEP, 32'(ONE_FX));
    tick();
    tick();
    drain();
    write_reg(CFG_KEEP, 32'd0);
    tick();
    tick();
    drain();

    // Chaos with a half-cycle increment, which lands exactly on one.
    write_reg(CFG_MODE, 32'(MODE_CHAOS));
    write_reg(CFG_PHASE_INC, 32'h8000_0000);
    tick();
    tick();
    tick();
    drain();

    // Unused mode: hold the value, leave the LFSR alone.
    write_reg(CFG_MODE, 32'(MODE_UNUSED));
    tick();
    tick();
    drain();

    // Random phases: mostly ticks with table writes mixed in, each phase
    // under its own setting and pacing. Now and then pause the sender until
    // the output side is empty.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      random_config();
      batch = $urandom_range(20, 150);
      repeat (batch) begin
        if ($urandom_range(0, 6) == 0)
          send_word(OP_SEQ_WRITE, SEQ_IDX_W'($urandom()), FX_W'($urandom()));
        else
          tick();
        sent++;
        if ($urandom_range(0, 199) == 0) drain();
      end
      drain();
    end

    if (mismatches == 0 && mod_values_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### random_step_modulator.f
src/rsm_pkg.sv
src/random_step_modulator.sv
src/rsm_checker.sv
dv/random_step_modulator_checker.sv
dv/random_step_modulator_tb.sv
